// ===== design/tlcd_pkg.sv =====
// Shared constants and types of the trail line crossing detector.
package tlcd_pkg;

    localparam int COORD_WIDTH_DEFAULT = 16;
    localparam int CFG_INDEX_WIDTH     = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_LINE_START_X = 2'd0,
        CFG_LINE_START_Y = 2'd1,
        CFG_LINE_END_X   = 2'd2,
        CFG_LINE_END_Y   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        SIGN_ZERO = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } sign_t;

endpackage

// ===== design/tlcd_point_if.sv =====
// Input channel: one trail point per transaction.
interface tlcd_point_if #(
    parameter int COORD_WIDTH = tlcd_pkg::COORD_WIDTH_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic                          new_trail;

    modport source (output valid, output point_x, output point_y, output new_trail,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input new_trail,
                    output ready);
endinterface

// ===== design/tlcd_result_if.sv =====
// Output channel: one crossing result per transaction.
interface tlcd_result_if;
    logic valid;
    logic ready;
    logic segment_valid;
    logic segment_hits;
    logic trail_crossed;

    modport source (output valid, output segment_valid, output segment_hits,
                    output trail_crossed, input ready);
    modport sink   (input valid, input segment_valid, input segment_hits,
                    input trail_crossed, output ready);
endinterface

// ===== design/tlcd_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface tlcd_cfg_if #(
    parameter int COORD_WIDTH = tlcd_pkg::COORD_WIDTH_DEFAULT
);
    logic                                 valid;
    logic                                 ready;
    logic [tlcd_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [COORD_WIDTH-1:0]               data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/trail_line_crossing_detector_unit.sv =====
// Top level of the trail line crossing detector.
//
//   channel  | modport | payload                                     | accepted when
//   ---------+---------+---------------------------------------------+---------------
//   cfg      | sink    | index, data                                 | valid && ready
//   point    | sink    | point_x, point_y, new_trail                 | valid && ready
//   result   | source  | segment_valid, segment_hits, trail_crossed  | valid && ready
//
// Two register stages: a point register, then a result register. The four
// orientation tests (two parallel multipliers each) and the box compares sit
// between them, so a point passes the point register, then the result register,
// and one point can be accepted every cycle unless both stages are full and stalled.
// Reset clears the line registers, trail history and both stage valid flags.
// A stalled result holds the result register; the point stage stalls behind it
// only when both stages are full. Configuration writes are always taken.
module trail_line_crossing_detector_unit #(
    parameter int COORD_WIDTH = tlcd_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    tlcd_cfg_if.sink      cfg,
    tlcd_point_if.sink    point,
    tlcd_result_if.source result
);
    import tlcd_pkg::*;

    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int PROD_WIDTH = 2 * COORD_WIDTH + 2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    // Reference line, held in configuration.
    coord_t line_start_x_reg, line_start_y_reg, line_end_x_reg, line_end_y_reg;

    // Trail history, updated as each point is accepted.
    coord_t previous_x_reg, previous_y_reg;
    logic   have_previous_reg;

    // Point stage.
    logic   s1_valid_reg;
    coord_t s1_prev_x_reg, s1_prev_y_reg, s1_cur_x_reg, s1_cur_y_reg;
    logic   s1_have_prev_reg;
    logic   s1_new_trail_reg;

    // Result stage.
    logic   out_valid_reg;
    logic   out_segment_valid_reg;
    logic   out_segment_hits_reg;
    logic   crossed_sticky_reg;
    logic   crossed_sticky_next;

    logic   out_load;
    logic   in_take;
    logic   hits;

    // Sign of (a - o) x (b - o), computed exactly.
    function automatic sign_t orient(input coord_t ox, input coord_t oy,
                                     input coord_t ax, input coord_t ay,
                                     input coord_t bx, input coord_t by);
        logic signed [DIFF_WIDTH-1:0] dax, day, dbx, dby;
        logic signed [PROD_WIDTH-1:0] p1, p2;
        sign_t                        s;
        dax = DIFF_WIDTH'(ax) - DIFF_WIDTH'(ox);
        day = DIFF_WIDTH'(ay) - DIFF_WIDTH'(oy);
        dbx = DIFF_WIDTH'(bx) - DIFF_WIDTH'(ox);
        dby = DIFF_WIDTH'(by) - DIFF_WIDTH'(oy);
        p1  = PROD_WIDTH'(dax) * PROD_WIDTH'(dby);
        p2  = PROD_WIDTH'(day) * PROD_WIDTH'(dbx);
        priority if (p1 > p2)
            s = SIGN_POS;
        else if (p1 < p2)
            s = SIGN_NEG;
        else
            s = SIGN_ZERO;
        return s;
    endfunction

    // Inclusive bounding-box test of p against the box spanned by a and b.
    function automatic logic in_box(input coord_t px, input coord_t py,
                                    input coord_t ax, input coord_t ay,
                                    input coord_t bx, input coord_t by);
        logic in_x, in_y;
        in_x = (px >= ax && px <= bx) || (px >= bx && px <= ax);
        in_y = (py >= ay && py <= by) || (py >= by && py <= ay);
        return in_x && in_y;
    endfunction

    // Handshake: the result register loads when empty or being drained; the
    // point stage empties into it, and refills from the input in the same cycle.
    assign out_load    = !out_valid_reg || result.ready;
    assign in_take     = point.valid && point.ready;
    assign point.ready = !s1_valid_reg || out_load;
    assign cfg.ready   = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_start_x_reg <= '0;
            line_start_y_reg <= '0;
            line_end_x_reg   <= '0;
            line_end_y_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_LINE_START_X: line_start_x_reg <= cfg.data;
                CFG_LINE_START_Y: line_start_y_reg <= cfg.data;
                CFG_LINE_END_X:   line_end_x_reg   <= cfg.data;
                CFG_LINE_END_Y:   line_end_y_reg   <= cfg.data;
            endcase
        end
    end

    // Take a point: record it as history, and latch it with its predecessor.
    // A new trail drops the predecessor so no segment is formed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_previous_reg <= 1'b0;
            s1_valid_reg      <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                have_previous_reg <= 1'b1;
                s1_valid_reg      <= 1'b1;
            end
            else if (out_load)
            begin
                s1_valid_reg      <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            previous_x_reg   <= point.point_x;
            previous_y_reg   <= point.point_y;
            s1_prev_x_reg    <= previous_x_reg;
            s1_prev_y_reg    <= previous_y_reg;
            s1_cur_x_reg     <= point.point_x;
            s1_cur_y_reg     <= point.point_y;
            s1_have_prev_reg <= have_previous_reg && !point.new_trail;
            s1_new_trail_reg <= point.new_trail;
        end
    end

    // Segment (previous -> current) against the reference line.
    always_comb
    begin
        sign_t o1, o2, o3, o4;
        o1 = orient(s1_prev_x_reg, s1_prev_y_reg, s1_cur_x_reg, s1_cur_y_reg,
                    line_start_x_reg, line_start_y_reg);
        o2 = orient(s1_prev_x_reg, s1_prev_y_reg, s1_cur_x_reg, s1_cur_y_reg,
                    line_end_x_reg, line_end_y_reg);
        o3 = orient(line_start_x_reg, line_start_y_reg, line_end_x_reg, line_end_y_reg,
                    s1_prev_x_reg, s1_prev_y_reg);
        o4 = orient(line_start_x_reg, line_start_y_reg, line_end_x_reg, line_end_y_reg,
                    s1_cur_x_reg, s1_cur_y_reg);
        // Proper crossing, or a collinear endpoint inside the other segment's box.
        hits = ((o1 != o2) && (o3 != o4))
            || (o1 == SIGN_ZERO && in_box(line_start_x_reg, line_start_y_reg,
                                          s1_prev_x_reg, s1_prev_y_reg,
                                          s1_cur_x_reg, s1_cur_y_reg))
            || (o2 == SIGN_ZERO && in_box(line_end_x_reg, line_end_y_reg,
                                          s1_prev_x_reg, s1_prev_y_reg,
                                          s1_cur_x_reg, s1_cur_y_reg))
            || (o3 == SIGN_ZERO && in_box(s1_prev_x_reg, s1_prev_y_reg,
                                          line_start_x_reg, line_start_y_reg,
                                          line_end_x_reg, line_end_y_reg))
            || (o4 == SIGN_ZERO && in_box(s1_cur_x_reg, s1_cur_y_reg,
                                          line_start_x_reg, line_start_y_reg,
                                          line_end_x_reg, line_end_y_reg));
        // Sticky flag: clear on a new trail, then set on a tested hit.
        crossed_sticky_next = (crossed_sticky_reg && !s1_new_trail_reg)
                           || (s1_have_prev_reg && hits);
    end

    // Result register and sticky flag advance together with the point stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg      <= 1'b0;
            crossed_sticky_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                crossed_sticky_reg <= crossed_sticky_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            out_segment_valid_reg <= s1_have_prev_reg;
            out_segment_hits_reg  <= s1_have_prev_reg && hits;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.segment_valid = out_segment_valid_reg;
    assign result.segment_hits  = out_segment_hits_reg;
    assign result.trail_crossed = crossed_sticky_reg;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of the trail line crossing detector: scoreboard class and drivers.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tlcd_pkg::*;

    localparam int CW          = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 3;       // wait after the last result, beyond the two register stages
    localparam int HOLD_CYCLES = 400;     // long result stall that backs up the pipeline
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 115;

    typedef logic signed [CW-1:0] coord_t;

    // One expected result transaction.
    typedef struct packed {
        logic seg_valid;
        logic seg_hits;
        logic crossed;
    } crossing_t;

    // Scoreboard: mirrors the line registers and the trail history, and keeps
    // the expected results in order of acceptance.
    class crossing_book;
        coord_t    line_sx, line_sy, line_ex, line_ey;
        coord_t    prev_x, prev_y;
        bit        have_prev;
        bit        sticky;
        crossing_t expected_q[$];
        int        errors;

        function new();
            line_sx   = '0;
            line_sy   = '0;
            line_ex   = '0;
            line_ey   = '0;
            prev_x    = '0;
            prev_y    = '0;
            have_prev = 1'b0;
            sticky    = 1'b0;
            errors    = 0;
        endfunction

        function void set_line(cfg_index_t idx, logic [CW-1:0] data);
            case (idx)
                CFG_LINE_START_X: line_sx = data;
                CFG_LINE_START_Y: line_sy = data;
                CFG_LINE_END_X:   line_ex = data;
                CFG_LINE_END_Y:   line_ey = data;
                default: ;
            endcase
        endfunction

        // Which side of the directed line o->a the point b lies on.
        function sign_t orientation(longint ox, longint oy, longint ax, longint ay,
                                    longint bx, longint by);
            longint turn;
            turn = (ax - ox) * (by - oy) - (ay - oy) * (bx - ox);
            if (turn > 0)
                return SIGN_POS;
            if (turn < 0)
                return SIGN_NEG;
            return SIGN_ZERO;
        endfunction

        function bit in_box(longint px, longint py, longint ax, longint ay,
                            longint bx, longint by);
            longint lox, hix, loy, hiy;
            lox = (ax < bx) ? ax : bx;
            hix = (ax < bx) ? bx : ax;
            loy = (ay < by) ? ay : by;
            hiy = (ay < by) ? by : ay;
            return px >= lox && px <= hix && py >= loy && py <= hiy;
        endfunction

        function bit segments_touch(longint p1x, longint p1y, longint p2x, longint p2y,
                                    longint q1x, longint q1y, longint q2x, longint q2y);
            sign_t o1, o2, o3, o4;
            o1 = orientation(p1x, p1y, p2x, p2y, q1x, q1y);
            o2 = orientation(p1x, p1y, p2x, p2y, q2x, q2y);
            o3 = orientation(q1x, q1y, q2x, q2y, p1x, p1y);
            o4 = orientation(q1x, q1y, q2x, q2y, p2x, p2y);
            if (o1 != o2 && o3 != o4)
                return 1'b1;
            if (o1 == SIGN_ZERO && in_box(q1x, q1y, p1x, p1y, p2x, p2y))
                return 1'b1;
            if (o2 == SIGN_ZERO && in_box(q2x, q2y, p1x, p1y, p2x, p2y))
                return 1'b1;
            if (o3 == SIGN_ZERO && in_box(p1x, p1y, q1x, q1y, q2x, q2y))
                return 1'b1;
            if (o4 == SIGN_ZERO && in_box(p2x, p2y, q1x, q1y, q2x, q2y))
                return 1'b1;
            return 1'b0;
        endfunction

        function void note_point(coord_t x, coord_t y, logic fresh);
            crossing_t want;
            bit        hit;
            if (fresh)
            begin
                have_prev = 1'b0;
                sticky    = 1'b0;
            end
            want = '0;
            if (have_prev)
            begin
                hit = segments_touch(prev_x, prev_y, x, y, line_sx, line_sy, line_ex, line_ey);
                want.seg_valid = 1'b1;
                want.seg_hits  = hit;
                if (hit)
                    sticky = 1'b1;
            end
            want.crossed = sticky;
            prev_x    = x;
            prev_y    = y;
            have_prev = 1'b1;
            expected_q = {expected_q, want};
        endfunction

        function void check_result(logic sv, logic sh, logic tc);
            crossing_t want;
            if (expected_q.size() == 0)
            begin
                $error("result with no point pending: segment_valid=%0b segment_hits=%0b %s%0b",
                       sv, sh, "trail_crossed=", tc);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (sv !== want.seg_valid)
            begin
                $error("segment_valid: expected %0b, actual %0b", want.seg_valid, sv);
                errors++;
            end
            if (sh !== want.seg_hits)
            begin
                $error("segment_hits: expected %0b, actual %0b", want.seg_hits, sh);
                errors++;
            end
            if (tc !== want.crossed)
            begin
                $error("trail_crossed: expected %0b, actual %0b", want.crossed, tc);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tlcd_cfg_if    #(.COORD_WIDTH(CW)) cfg_bus ();
    tlcd_point_if  #(.COORD_WIDTH(CW)) point_bus ();
    tlcd_result_if                     result_bus ();

    trail_line_crossing_detector_unit #(.COORD_WIDTH(CW)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .point  (point_bus),
        .result (result_bus)
    );

    crossing_book book = new();

    int     send_idle_pct;
    int     recv_idle_pct;
    bit     stall_request;
    int     cycle_count;
    // Line currently programmed and the last point sent; they steer the random points.
    coord_t cur_sx, cur_sy, cur_ex, cur_ey;
    coord_t last_x, last_y;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: end the run if the stimulus or the results get stuck.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result sink: check every accepted result, then pick ready for the next edge.
    // A stall request holds ready low for a long stretch counted here.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready)
                book.check_result(result_bus.segment_valid, result_bus.segment_hits,
                                  result_bus.trail_crossed);
            if (stall_request)
            begin
                stall_left    = HOLD_CYCLES;
                stall_request = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one point; idle first at the sender's rate, then hold valid until taken.
    // Valid stays high on exit so back-to-back points need no extra edge.
    task automatic send_point(input coord_t x, input coord_t y, input logic fresh);
        while ($urandom_range(99) < send_idle_pct)
        begin
            point_bus.valid <= 1'b0;
            @(posedge clk);
        end
        point_bus.valid     <= 1'b1;
        point_bus.point_x   <= x;
        point_bus.point_y   <= y;
        point_bus.new_trail <= fresh;
        @(posedge clk);
        while (!point_bus.ready)
            @(posedge clk);
        book.note_point(x, y, fresh);
        last_x = x;
        last_y = y;
    endtask

    // Drop valid and wait until every expected result has come, plus the pipeline depth.
    task automatic drain_points();
        point_bus.valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Program all four line registers; call only with the pipeline empty.
    task automatic write_line(input coord_t sx, input coord_t sy,
                              input coord_t ex, input coord_t ey);
        coord_t     vals[4];
        cfg_index_t idx;
        vals[0] = sx;
        vals[1] = sy;
        vals[2] = ex;
        vals[3] = ey;
        for (int i = 0; i < 4; i++)
        begin
            idx = cfg_index_t'(i);
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx;
            cfg_bus.data  <= vals[i];
            @(posedge clk);
            while (!cfg_bus.ready)
                @(posedge clk);
            book.set_line(idx, vals[i]);
        end
        cfg_bus.valid <= 1'b0;
        cur_sx = sx;
        cur_sy = sy;
        cur_ex = ex;
        cur_ey = ey;
    endtask

    // Uniform value in the span of a and b widened by margin, clamped to the field.
    function automatic coord_t near_span(coord_t a, coord_t b, int margin);
        int lo, hi;
        lo = ((a < b) ? a : b) - margin;
        hi = ((a < b) ? b : a) + margin;
        if (lo < -32768)
            lo = -32768;
        if (hi > 32767)
            hi = 32767;
        return coord_t'(lo + int'($urandom_range(hi - lo)));
    endfunction

    function automatic coord_t extreme_coord();
        case ($urandom_range(3))
            0:       return coord_t'(-32768);
            1:       return coord_t'(32767);
            2:       return coord_t'(0);
            default: return coord_t'(-1);
        endcase
    endfunction

    // Random point: mostly around the line so crossings and touches are common,
    // also line endpoints, full-range noise, field extremes and repeated points.
    task automatic pick_point(output coord_t x, output coord_t y);
        int kind;
        int margin;
        kind   = $urandom_range(9);
        margin = $urandom_range(8);
        case (kind)
            0, 1, 2, 3:
            begin
                x = near_span(cur_sx, cur_ex, margin);
                y = near_span(cur_sy, cur_ey, margin);
            end
            4:
            begin
                x = cur_sx;
                y = cur_sy;
            end
            5:
            begin
                x = cur_ex;
                y = cur_ey;
            end
            6, 7:
            begin
                x = coord_t'($urandom);
                y = coord_t'($urandom);
            end
            8:
            begin
                x = extreme_coord();
                y = extreme_coord();
            end
            default:
            begin
                x = last_x;
                y = last_y;
            end
        endcase
    endtask

    // Line setting of each random phase: the diagonals across the whole field,
    // short and degenerate lines, a vertical line on the edge and random ones.
    task automatic program_phase_line(input int ph);
        coord_t a, b, c, d;
        case (ph)
            1: write_line(-32768, -32768, 32767, 32767);
            2: write_line(32767, -32768, -32768, 32767);
            3: write_line(-5, 3, 7, 3);
            5:
            begin
                a = coord_t'($urandom);
                b = coord_t'($urandom);
                write_line(a, b, a, b);
            end
            6:
            begin
                a = coord_t'(int'($urandom_range(40)) - 20);
                b = coord_t'(int'($urandom_range(40)) - 20);
                c = coord_t'(int'($urandom_range(40)) - 20);
                d = coord_t'(int'($urandom_range(40)) - 20);
                write_line(a, b, c, d);
            end
            8: write_line(32767, -32768, 32767, 32767);
            9:
            begin
                a = coord_t'(int'($urandom_range(600)) - 300);
                b = coord_t'(int'($urandom_range(600)) - 300);
                c = coord_t'(int'($urandom_range(600)) - 300);
                d = coord_t'(int'($urandom_range(600)) - 300);
                write_line(a, b, c, d);
            end
            default:
            begin
                a = coord_t'($urandom);
                b = coord_t'($urandom);
                c = coord_t'($urandom);
                d = coord_t'($urandom);
                write_line(a, b, c, d);
            end
        endcase
    endtask

    initial
    begin : stimulus
        coord_t px, py;
        logic   fresh;

        // Drive every input to a known value from time zero and hold reset.
        rst_n               <= 1'b0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= CFG_LINE_START_X;
        cfg_bus.data        <= '0;
        point_bus.valid     <= 1'b0;
        point_bus.point_x   <= '0;
        point_bus.point_y   <= '0;
        point_bus.new_trail <= 1'b0;
        cycle_count         = 0;
        stall_request       = 1'b0;
        send_idle_pct       = 21;
        recv_idle_pct       = 59;
        cur_sx = '0;
        cur_sy = '0;
        cur_ex = '0;
        cur_ey = '0;
        last_x = '0;
        last_y = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset line, a single point at the origin.
        send_point(5, 5, 1'b0);          // first point after reset: no segment yet
        send_point(-5, -5, 1'b0);        // segment through the point-sized line
        send_point(10, -5, 1'b0);        // miss, crossed flag holds
        send_point(0, 0, 1'b1);          // new trail clears history
        send_point(0, 0, 1'b0);          // point-sized segment on a point-sized line
        drain_points();

        // Directed part on a horizontal line.
        write_line(-100, 0, 100, 0);
        send_point(0, -10, 1'b1);
        send_point(0, 10, 1'b0);         // proper crossing
        send_point(0, 20, 1'b0);         // miss, crossed flag stays set
        send_point(100, 0, 1'b1);        // new trail starting on the line end
        send_point(150, 0, 1'b0);        // collinear, touches at the endpoint
        send_point(200, 0, 1'b0);        // collinear, outside the line
        send_point(-32768, -32768, 1'b1);
        send_point(32767, 32767, 1'b0);  // full-field diagonal through the line
        send_point(32767, -32768, 1'b0);
        send_point(-32768, 32767, 1'b0);
        send_point(-32768, 0, 1'b0);     // ends on the line's extension, far outside the line
        send_point(-100, 0, 1'b0);       // ends on the line start
        send_point(-100, 0, 1'b0);       // zero-length segment on the line
        send_point(-101, 0, 1'b1);
        send_point(-101, 0, 1'b0);       // zero-length segment off the line
        send_point(0, 1, 1'b0);
        drain_points();

        // Random phases: sender idles 21 / receiver 59, then swapped, then no idling.
        for (int ph = 1; ph <= PHASES; ph++)
        begin
            if (ph <= 3)
            begin
                send_idle_pct = 21;
                recv_idle_pct = 59;
            end
            else if (ph <= 6)
            begin
                send_idle_pct = 59;
                recv_idle_pct = 21;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            program_phase_line(ph);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Back up the pipeline: long result stall while points keep coming.
                if (ph == 7 && n == 30)
                    stall_request = 1'b1;
                // Pause the sender until every result is back.
                if (ph == 4 && n == 60)
                begin
                    point_bus.valid <= 1'b0;
                    while (book.pending() != 0)
                        @(posedge clk);
                end
                pick_point(px, py);
                fresh = ($urandom_range(9) == 0);
                send_point(px, py, fresh);
            end
            drain_points();
        end

        // Everything is back; wait on for any stray result.
        repeat (10) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ===== trail_line_crossing_detector_unit.f =====
design/tlcd_pkg.sv
design/tlcd_point_if.sv
design/tlcd_result_if.sv
design/tlcd_cfg_if.sv
design/trail_line_crossing_detector_unit.sv
test/testbench.sv
